[hdl/command_id_dedup_cache_macros.svh]
// assertion macros for the dedup cache checker
`ifndef COMMAND_ID_DEDUP_CACHE_MACROS_SVH
`define COMMAND_ID_DEDUP_CACHE_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define DDC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define DDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hdl/ddc_pkg.sv]
// shared constants and types for the dedup cache
`default_nettype none
package ddc_pkg;
    localparam int DEPTH_DEFAULT    = 128;
    localparam int KEY_BITS_DEFAULT = 64;
    localparam logic [31:0] TTL_RESET = 32'd300000;
    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_PROGRESS = 2'd1;
    localparam logic [1:0] ST_DONE     = 2'd2;
    localparam logic [1:0] ST_FAILED   = 2'd3;
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

[hdl/ddc_cell.sv]
// one cache entry; the entries form a rotating ring
`default_nettype none
module ddc_cell import ddc_pkg::*; #(
    parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                shift,
    input  wire logic                load_en,
    input  wire logic [KEY_BITS-1:0] in_key,
    input  wire logic [63:0]         in_time,
    input  wire logic                in_valid,
    input  wire logic                in_has_final,
    input  wire logic                in_failed,
    output logic [KEY_BITS-1:0]      out_key,
    output logic [63:0]              out_time,
    output logic                     out_valid,
    output logic                     out_has_final,
    output logic                     out_failed
);
    logic [KEY_BITS-1:0] key_reg;
    logic [63:0]         time_reg;
    logic                valid_reg, has_final_reg, failed_reg;

    always_ff @(posedge clk)
    begin
        if (shift || load_en)
        begin
            key_reg  <= in_key;
            time_reg <= in_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            has_final_reg <= 1'b0;
            failed_reg    <= 1'b0;
        end
        else if (shift || load_en)
        begin
            valid_reg     <= in_valid;
            has_final_reg <= in_has_final;
            failed_reg    <= in_failed;
        end
    end

    assign out_key       = key_reg;
    assign out_time      = time_reg;
    assign out_valid     = valid_reg;
    assign out_has_final = has_final_reg;
    assign out_failed    = failed_reg;
endmodule
`default_nettype wire

[hdl/command_id_dedup_cache.sv]
// top level of the duplicate-command cache
// The cache keeps DEPTH entries in a ring of cells that rotates by one place
// per clock while an item is scanned. An item is accepted in the idle state;
// then the ring turns once past the head cell, where each entry is compared,
// expired or updated; then the result is presented in the output register.
// The full turn brings every entry back to its own slot, so index order and
// the round-robin pointer keep their meaning. Only one item is in flight; the
// input stalls while it runs and while a result waits. The time-to-live
// register may be written while idle.
`default_nettype none
module command_id_dedup_cache import ddc_pkg::*; #(
    parameter int DEPTH    = DEPTH_DEFAULT,
    parameter int KEY_BITS = KEY_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [63:0] key,
    input  wire logic [63:0] now_ms,
    input  wire logic        final_code,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             hit,
    output logic [1:0]       status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    state_t state_reg, state_next;
    logic [31:0]         ttl_reg;
    logic [PW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                op_reg, code_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [63:0]         now_reg;
    logic                found_reg, found_next;
    logic [1:0]          res_reg, res_next;
    logic                hit_reg, hit_next;
    logic [1:0]          status_reg, status_next;

    // ring wires: cell i feeds cell i-1, head (cell 0) wraps to the tail
    logic [KEY_BITS-1:0] c_key   [DEPTH];
    logic [63:0]         c_time  [DEPTH];
    logic                c_val   [DEPTH];
    logic                c_hf    [DEPTH];
    logic                c_fail  [DEPTH];
    logic [KEY_BITS-1:0] h_key;
    logic [63:0]         h_time;
    logic                h_val, h_hf, h_fail;
    logic                shift, last, miss_ins;
    logic [63:0]         age;
    logic                expired, match;

    assign shift = (state_reg == S_SCAN);
    assign last  = (cnt_reg == CW'(DEPTH - 1));
    assign age   = now_reg - c_time[0];
    assign expired = c_val[0] && (age > {32'd0, ttl_reg});
    assign match   = c_val[0] && (c_key[0] == key_reg);

    // head processing: modify the entry as it leaves cell 0 for the tail
    always_comb
    begin
        h_key  = c_key[0];
        h_time = c_time[0];
        h_val  = c_val[0];
        h_hf   = c_hf[0];
        h_fail = c_fail[0];
        found_next = found_reg;
        res_next   = res_reg;
        if (shift && !found_reg)
        begin
            if (op_reg == OP_LOOKUP)
            begin
                if (expired)
                begin
                    h_val = 1'b0;
                    h_hf  = 1'b0;
                end
                else if (match)
                begin
                    found_next = 1'b1;
                    if (c_hf[0])
                        res_next = c_fail[0] ? ST_FAILED : ST_DONE;
                    else
                    begin
                        res_next = ST_PROGRESS;
                        h_time   = now_reg;
                    end
                end
            end
            else if (match)
            begin
                found_next = 1'b1;
                h_hf       = 1'b1;
                h_fail     = code_reg;
                res_next   = code_reg ? ST_FAILED : ST_DONE;
            end
        end
    end

    // on a lookup miss the victim slot is written once the ring is home
    assign miss_ins = (state_reg == S_SCAN) && last && (op_reg == OP_LOOKUP)
                      && !found_next;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_ring
            logic                ld;
            logic [KEY_BITS-1:0] nk;
            logic [63:0]         nt;
            logic                nv, nh, nf;
            if (g == DEPTH - 1)
            begin : g_tail
                assign nk = h_key;
                assign nt = h_time;
                assign nv = h_val;
                assign nh = h_hf;
                assign nf = h_fail;
            end
            else
            begin : g_mid
                assign nk = c_key[g+1];
                assign nt = c_time[g+1];
                assign nv = c_val[g+1];
                assign nh = c_hf[g+1];
                assign nf = c_fail[g+1];
            end
            assign ld = miss_ins && (ptr_reg == PW'(g));
            ddc_cell #(.KEY_BITS(KEY_BITS)) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .shift        (shift && !ld),
                .load_en      (ld),
                .in_key       (ld ? key_reg : nk),
                .in_time      (ld ? now_reg : nt),
                .in_valid     (ld ? 1'b1 : nv),
                .in_has_final (ld ? 1'b0 : nh),
                .in_failed    (ld ? 1'b0 : nf),
                .out_key      (c_key[g]),
                .out_time     (c_time[g]),
                .out_valid    (c_val[g]),
                .out_has_final(c_hf[g]),
                .out_failed   (c_fail[g])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_SCAN;
            S_SCAN: if (last) state_next = S_OUT;
            S_OUT:  if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb
    begin
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        hit_next    = hit_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE: cnt_next = '0;
            S_SCAN:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (last)
                begin
                    hit_next    = found_next;
                    status_next = found_next ? res_next : ST_NONE;
                    if (miss_ins)
                        ptr_next = (ptr_reg == PW'(DEPTH - 1)) ? '0 : ptr_reg + PW'(1);
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall  = (state_reg != S_IDLE);
        out_valid = (state_reg == S_OUT);
        cfg_ready = (state_reg == S_IDLE);
    end
    assign hit    = hit_reg;
    assign status = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ttl_reg   <= TTL_RESET;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            found_reg <= (state_reg == S_IDLE) ? 1'b0 : found_next;
            if (cfg_valid && cfg_ready)
                ttl_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg   <= op;
            code_reg <= final_code;
            key_reg  <= key[KEY_BITS-1:0];
            now_reg  <= now_ms;
        end
        res_reg    <= res_next;
        hit_reg    <= hit_next;
        status_reg <= status_next;
    end
endmodule
`default_nettype wire

[hdl/ddc_checker.sv]
// port-level checker for the dedup cache, bound to the top level
`default_nettype none
`include "command_id_dedup_cache_macros.svh"
module ddc_checker import ddc_pkg::*; (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       hit,
    input wire logic [1:0] status
);
    // a miss never reports a status
    `DDC_ASSERT_IMP(a_miss_none, clk, rst_n, out_valid && !hit, status == ST_NONE, "miss with status")
    // a hit always reports a status
    `DDC_ASSERT_IMP(a_hit_status, clk, rst_n, out_valid && hit, status != ST_NONE, "hit without status")
    // one item at a time: input stalled while a result is shown
    `DDC_ASSERT_IMP(a_one_item, clk, rst_n, out_valid, in_stall, "input open with result pending")
    // an accepted item blocks the input next cycle
    `DDC_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall && !out_valid,
        "no busy after accept")
    // a stalled result holds
    `DDC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(hit) && $stable(status), "result changed under stall")
endmodule

bind command_id_dedup_cache ddc_checker u_ddc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit      (hit),
    .status   (status)
);
`default_nettype wire

[dv/command_id_dedup_cache_test.sv]
// self-checking testbench for the duplicate-command cache
`timescale 1ns / 1ps
`default_nettype none
module command_id_dedup_cache_test;
    import ddc_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic        op;
        logic [63:0] key;
        logic [63:0] now_ms;
        logic        final_code;
    } command_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] status;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = 1'b0;
    logic [63:0] key = '0;
    logic [63:0] now_ms = '0;
    logic        final_code = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        hit;
    logic [1:0]  status;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    // predictor copy of the cache contents
    logic [63:0] cache_key [DEPTH];
    logic [63:0] cache_time [DEPTH];
    logic        cache_valid [DEPTH];
    logic        cache_has_final [DEPTH];
    logic        cache_failed [DEPTH];
    int          victim_ptr;
    logic [31:0] ttl_model;

    command_t pending_cmds[$];
    verdict_t expected_verdicts[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off = 0;     // receiver hold-off cycles still to run
    int mismatches = 0;
    int verdicts_seen = 0;
    int hits_seen = 0;
    int cycles = 0;

    command_id_dedup_cache DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .key(key), .now_ms(now_ms), .final_code(final_code),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // predicts the verdict of one command and updates the cache copy
    function automatic verdict_t dedup_predict(command_t c);
        verdict_t v;
        int i;
        v.hit = 1'b0;
        v.status = ST_NONE;
        if (c.op == OP_LOOKUP)
        begin
            for (i = 0; i < DEPTH; i++)
            begin
                if (!cache_valid[i])
                    continue;
                // wrapping age beyond ttl expires the entry on the way
                if (c.now_ms - cache_time[i] > {32'd0, ttl_model})
                begin
                    cache_valid[i] = 1'b0;
                    cache_has_final[i] = 1'b0;
                    continue;
                end
                if (cache_key[i] == c.key)
                begin
                    v.hit = 1'b1;
                    if (cache_has_final[i])
                        v.status = cache_failed[i] ? ST_FAILED : ST_DONE;
                    else
                    begin
                        cache_time[i] = c.now_ms;
                        v.status = ST_PROGRESS;
                    end
                    return v;
                end
            end
            // miss: overwrite the round-robin victim
            cache_key[victim_ptr] = c.key;
            cache_time[victim_ptr] = c.now_ms;
            cache_valid[victim_ptr] = 1'b1;
            cache_has_final[victim_ptr] = 1'b0;
            cache_failed[victim_ptr] = 1'b0;
            victim_ptr = (victim_ptr + 1) % DEPTH;
        end
        else
        begin
            // record ignores the ttl
            for (i = 0; i < DEPTH; i++)
            begin
                if (cache_valid[i] && cache_key[i] == c.key)
                begin
                    cache_has_final[i] = 1'b1;
                    cache_failed[i] = c.final_code;
                    v.hit = 1'b1;
                    v.status = c.final_code ? ST_FAILED : ST_DONE;
                    return v;
                end
            end
        end
        return v;
    endfunction

    // driver: presents pending commands, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_verdicts.push_back(dedup_predict({op, key, now_ms, final_code}));
            if (!in_valid || !in_stall)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    command_t c;
                    c = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    op <= c.op;
                    key <= c.key;
                    now_ms <= c.now_ms;
                    final_code <= c.final_code;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compares each verdict with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            verdicts_seen <= verdicts_seen + 1;
            if (hit)
                hits_seen <= hits_seen + 1;
            if (expected_verdicts.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected item: hit=%0b status=%0d", hit, status);
            end
            else
            begin
                verdict_t e;
                e = expected_verdicts.pop_front();
                if (e.hit !== hit || e.status !== status)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected hit=%0b status=%0d, got hit=%0b status=%0d",
                                 e.hit, e.status, hit, status);
                end
            end
        end
    end

    // receiver stall: long hold-off when requested, else random
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic queue_cmd(logic o, logic [63:0] k, logic [63:0] t, logic f);
        command_t c;
        c.op = o;
        c.key = k;
        c.now_ms = t;
        c.final_code = f;
        pending_cmds.push_back(c);
    endtask

    task automatic drain;
        while (pending_cmds.size() > 0 || in_valid || expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (DEPTH + 10) @(posedge clk);
    endtask

    task automatic write_ttl(logic [31:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        ttl_model = v;
    endtask

    // random phase: keys from a small pool so hits and records land
    task automatic random_phase(int n, logic [63:0] t0);
        logic [63:0] pool [16];
        logic [63:0] t;
        int i;
        for (i = 0; i < 16; i++)
            pool[i] = {$urandom, $urandom};
        t = t0;
        for (i = 0; i < n; i++)
        begin
            logic [63:0] k;
            int r;
            r = $urandom_range(99);
            if (r < 5)
                t = {$urandom, $urandom};          // time jump, maybe backward
            else
                t = t + 64'($urandom_range(2000));
            k = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                         : pool[4'($urandom_range(15))];
            queue_cmd($urandom_range(2) == 0, k, t, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        int i;
        for (i = 0; i < DEPTH; i++)
        begin
            cache_key[i] = '0;
            cache_time[i] = '0;
            cache_valid[i] = 1'b0;
            cache_has_final[i] = 1'b0;
            cache_failed[i] = 1'b0;
        end
        victim_ptr = 0;
        ttl_model = TTL_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: miss, in progress, record done/failed, expiry, record miss
        send_idle_pct = 13;
        recv_idle_pct = 82;
        queue_cmd(OP_RECORD, 64'h0, 64'h0, 1'b0);
        queue_cmd(OP_LOOKUP, 64'h0, 64'h0, 1'b0);
        queue_cmd(OP_LOOKUP, 64'h0, 64'd100, 1'b1);
        queue_cmd(OP_LOOKUP, '1, 64'd200, 1'b0);
        queue_cmd(OP_RECORD, '1, 64'd200, 1'b1);
        queue_cmd(OP_LOOKUP, '1, 64'd300, 1'b0);
        queue_cmd(OP_RECORD, 64'h0, 64'd300, 1'b0);
        queue_cmd(OP_LOOKUP, 64'h0, 64'd400, 1'b0);
        queue_cmd(OP_RECORD, 64'h0, '1, 1'b1);     // record past ttl still hits
        queue_cmd(OP_LOOKUP, 64'h0, 64'd400000, 1'b0); // expired
        queue_cmd(OP_LOOKUP, 64'h5555_AAAA_5555_AAAA, 64'd400000, 1'b0);
        queue_cmd(OP_LOOKUP, 64'h5555_AAAA_5555_AAAA, 64'd10, 1'b0); // time backwards
        queue_cmd(OP_LOOKUP, 64'hAAAA_5555_AAAA_5555, '1, 1'b0);
        drain();

        write_ttl(32'd0);
        queue_cmd(OP_LOOKUP, 64'd7, 64'd50, 1'b0);
        queue_cmd(OP_LOOKUP, 64'd7, 64'd50, 1'b0);
        queue_cmd(OP_LOOKUP, 64'd7, 64'd51, 1'b0);
        drain();

        write_ttl(32'hFFFF_FFFF);
        queue_cmd(OP_LOOKUP, 64'd9, 64'hFFFF_FFFF, 1'b0);
        queue_cmd(OP_LOOKUP, 64'd9, 64'h1_FFFF_FFFE, 1'b0);
        queue_cmd(OP_LOOKUP, 64'd9, 64'h2_FFFF_FFFF, 1'b0);
        // fill past depth so the victim pointer wraps
        for (i = 0; i < 140; i++)
            queue_cmd(OP_LOOKUP, 64'h1000 + i, 64'h3_0000_0000, 1'b0);
        drain();

        // long receiver hold-off while the sender keeps offering
        write_ttl(32'd5000);
        random_phase(350, 64'd1000);
        hold_off = 600;
        drain();

        send_idle_pct = 82;
        recv_idle_pct = 13;
        write_ttl(TTL_RESET);
        random_phase(280, 64'h8000_0000_0000_0000);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_ttl(32'd1500);
        random_phase(250, '1 - 64'd100000);
        drain();

        $display("checked %0d verdicts (%0d hits) over five ttl settings, %0d mismatches",
                 verdicts_seen, hits_seen, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/ddc_pkg.sv
hdl/ddc_cell.sv
hdl/command_id_dedup_cache.sv
hdl/ddc_checker.sv
dv/command_id_dedup_cache_test.sv
